### rtl/box_filter_2d_zero_pad_top_defines.svh
// ----------------------------------------------------------------------------
// Box filter assertion macros
// Shared wrappers for the concurrent checks of the box filter.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_2D_ZERO_PAD_TOP_DEFINES_SVH
`define BOX_FILTER_2D_ZERO_PAD_TOP_DEFINES_SVH

// same-cycle implication
`define BFZ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFZ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bfz_pkg.sv
// ----------------------------------------------------------------------------
// Box filter package
// Payload types, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package bfz_pkg;

   localparam int PIX_W        = 8;
   localparam int KSIZE_W      = 4;
   localparam int IWIDTH_W     = 11;
   localparam int IHEIGHT_W    = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_IDX_W    = 2;
   localparam int ROW_W        = 13;
   localparam int HEIGHT_LIMIT = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic             is_drain;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] averaged_pixel;
      logic             last_of_frame;
   } rsp_type;

endpackage

### rtl/bfz_line_mem.sv
// ----------------------------------------------------------------------------
// Box filter line memory
// Single write port, single registered read port pixel store.
// ----------------------------------------------------------------------------
module bfz_line_mem
   import bfz_pkg::*;
#(
   parameter int DEPTH = 15360,
   parameter int AW    = 14
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [PIX_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/bfz_div.sv
// ----------------------------------------------------------------------------
// Box filter divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfz_div
   import bfz_pkg::*;
#(
   parameter int NW = 16,
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CNT_W = $clog2(NW + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DW-1:0]    rem_ff;
   logic [NW-1:0]    quo_ff;
   logic [DW-1:0]    dsr_ff;
   logic             done_ff;
   logic [DW:0]      shifted;
   logic             fits;

   assign shifted  = {rem_ff, quo_ff[NW-1]};
   assign fits     = shifted >= {1'b0, dsr_ff};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
            cnt_ff  <= CNT_W'(NW);
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff  <= fits ? DW'(shifted - {1'b0, dsr_ff}) : shifted[DW-1:0];
            quo_ff  <= {quo_ff[NW-2:0], fits};
            cnt_ff  <= cnt_ff - 1'b1;
            done_ff <= (cnt_ff == CNT_W'(1));
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

endmodule

### rtl/box_filter_2d_zero_pad_top.sv
// ----------------------------------------------------------------------------
// Box filter 2D with zero padding
// Streaming k-by-k box average of raster-order grey pixels.
// ----------------------------------------------------------------------------
// Pixels enter on req_* (valid/ready), averages leave on rsp_* (valid/ready).
// Registers are written on csr_* only while the block is idle; the user
// must keep to this, the block does not enforce it. A write to any of the
// three register indexes restarts the frame. After the last pixel, drain
// items flush the remaining outputs. One item is handled at a time. An item
// that releases an output reads the k*k window pixels one per cycle through
// the single read port of the line memory, then a restoring divider produces
// one quotient bit per cycle (SUM_W is 16 at the default MAX_KERNEL).
// A finished result sits in the output register; the next item is accepted
// while it waits, and only a further result stalls until rsp_ready frees it.
// Reset (synchronous) restores k=9, 640x480 and the start of a frame; the
// line memory is not cleared, as only pixels of the current frame are read.
// ----------------------------------------------------------------------------
`include "box_filter_2d_zero_pad_top_defines.svh"

module box_filter_2d_zero_pad_top
   import bfz_pkg::*;
#(
   parameter int MAX_KERNEL = 15,
   parameter int MAX_WIDTH  = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int KW    = $clog2(MAX_KERNEL + 1);
   localparam int SLW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int XW    = WW + 2;
   localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int SUM_W = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
   localparam int DVW   = $clog2(MAX_KERNEL * MAX_KERNEL + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_SUM, ST_WAIT, ST_DIVS, ST_DIV, ST_PUSH
   } state_type;

   state_type            state_ff;
   logic [KSIZE_W-1:0]   ksize_ff;
   logic [IWIDTH_W-1:0]  iwidth_ff;
   logic [IHEIGHT_W-1:0] iheight_ff;

   logic [ROW_W-1:0] in_row_ff, out_row_ff;
   logic [CW-1:0]    in_col_ff, out_col_ff;
   logic [SLW-1:0]   in_slot_ff, out_slot_ff, slot_ff;

   logic signed [ROW_W:0] y_ff;
   logic signed [XW-1:0]  x_ff, x0_ff;
   logic [KW-1:0]         dy_ff, dx_ff;
   logic                  rd_valid_ff;
   logic [SUM_W-1:0]      acc_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [KW-1:0]    k_eff, radius, reach;
   logic [WW-1:0]    w_eff;
   logic [ROW_W-1:0] h_eff;
   logic [DVW-1:0]   kk;

   logic             req_fire, wr_en, inframe, slot_free, is_last;
   logic             csr_hit, push_fire;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [PIX_W-1:0] rd_data;
   logic [ROW_W:0]   need_r_full;
   logic [ROW_W-1:0] need_r;
   logic [WW:0]      need_c_full;
   logic [WW-1:0]    need_c;
   logic             out_ready, out_bad;
   logic             div_done;
   logic [SUM_W-1:0] div_quo;

   // clamp register values to their legal ranges
   always_comb begin
      if (ksize_ff == '0) begin
         k_eff = KW'(1);
      end else if (32'(ksize_ff) > MAX_KERNEL) begin
         k_eff = KW'(MAX_KERNEL);
      end else begin
         k_eff = KW'(ksize_ff);
      end
      if (iwidth_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(iwidth_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(iwidth_ff);
      end
      if (iheight_ff == '0) begin
         h_eff = ROW_W'(1);
      end else if (32'(iheight_ff) > HEIGHT_LIMIT) begin
         h_eff = ROW_W'(HEIGHT_LIMIT);
      end else begin
         h_eff = ROW_W'(iheight_ff);
      end
   end

   assign radius = k_eff >> 1;
   assign reach  = KW'(k_eff - KW'(1) - radius);
   assign kk     = DVW'(k_eff) * DVW'(k_eff);

   assign csr_hit   = csr_we && ((csr_index == CSR_KERNEL_SIZE) ||
                                 (csr_index == CSR_IMAGE_WIDTH) ||
                                 (csr_index == CSR_IMAGE_HEIGHT));
   assign req_ready = (state_ff == ST_IDLE) && !csr_we;
   assign req_fire  = req_valid && req_ready;
   assign wr_en     = req_fire && !req_data.is_drain && (in_row_ff < h_eff);
   assign wr_addr   = AW'(in_slot_ff) * AW'(MAX_WIDTH) + AW'(in_col_ff);

   // readiness: last in-frame pixel of the window already stored
   assign need_r_full = {1'b0, out_row_ff} + (ROW_W + 1)'(reach);
   assign need_r      = (need_r_full > {1'b0, h_eff - 1'b1}) ? h_eff - 1'b1
                                                            : need_r_full[ROW_W-1:0];
   assign need_c_full = (WW + 1)'(out_col_ff) + (WW + 1)'(reach);
   assign need_c      = (need_c_full > {1'b0, w_eff - 1'b1}) ? w_eff - 1'b1
                                                            : need_c_full[WW-1:0];
   assign out_ready   = (in_row_ff > need_r) ||
                        ((in_row_ff == need_r) && (WW'(in_col_ff) > need_c));
   assign out_bad     = (out_row_ff >= h_eff) || (WW'(out_col_ff) >= w_eff);

   assign inframe = !y_ff[ROW_W] && (y_ff[ROW_W-1:0] < h_eff) &&
                    !x_ff[XW-1] && (x_ff[XW-2:0] < (XW - 1)'(w_eff));
   assign rd_addr = AW'(slot_ff) * AW'(MAX_WIDTH) + AW'(x_ff[CW-1:0]);

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign push_fire = (state_ff == ST_PUSH) && slot_free && !csr_hit;
   assign is_last   = (out_row_ff == h_eff - 1'b1) &&
                      (WW'(out_col_ff) == w_eff - 1'b1);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bfz_line_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.pixel_value),
      .rd_en   ((state_ff == ST_SUM) && inframe),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bfz_div #(
      .NW (SUM_W),
      .DW (DVW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_DIVS),
      .dividend (acc_ff),
      .divisor  (kk),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ksize_ff     <= KSIZE_W'(9);
         iwidth_ff    <= IWIDTH_W'(640);
         iheight_ff   <= IHEIGHT_W'(480);
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_slot_ff   <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_slot_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= (state_ff == ST_SUM) && inframe;
         if (rd_valid_ff) begin
            acc_ff <= acc_ff + SUM_W'(rd_data);
         end
         if (push_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_hit) begin
            // register write restarts the frame
            in_row_ff   <= '0;
            in_col_ff   <= '0;
            in_slot_ff  <= '0;
            out_row_ff  <= '0;
            out_col_ff  <= '0;
            out_slot_ff <= '0;
         end else begin
            unique case (state_ff)
               ST_IDLE: begin
                  if (req_fire) begin
                     if (wr_en) begin
                        if (WW'(in_col_ff) + WW'(1) >= w_eff) begin
                           in_col_ff  <= '0;
                           in_row_ff  <= in_row_ff + 1'b1;
                           in_slot_ff <= (in_slot_ff == SLW'(MAX_KERNEL - 1)) ? '0
                                                                            : in_slot_ff + 1'b1;
                        end else begin
                           in_col_ff <= in_col_ff + 1'b1;
                        end
                     end
                     state_ff <= ST_CHECK;
                  end
               end
               ST_CHECK: begin
                  if (out_bad) begin
                     in_row_ff   <= '0;
                     in_col_ff   <= '0;
                     in_slot_ff  <= '0;
                     out_row_ff  <= '0;
                     out_col_ff  <= '0;
                     out_slot_ff <= '0;
                     state_ff    <= ST_IDLE;
                  end else if (out_ready) begin
                     y_ff   <= $signed({1'b0, out_row_ff}) - $signed((ROW_W + 1)'(radius));
                     x_ff   <= $signed(XW'(out_col_ff)) - $signed(XW'(radius));
                     x0_ff  <= $signed(XW'(out_col_ff)) - $signed(XW'(radius));
                     // memory row of the top window row, wrapped
                     slot_ff <= (out_slot_ff >= SLW'(radius))
                                ? SLW'(out_slot_ff - SLW'(radius))
                                : SLW'(out_slot_ff + SLW'(MAX_KERNEL) - SLW'(radius));
                     dy_ff    <= '0;
                     dx_ff    <= '0;
                     acc_ff   <= '0;
                     state_ff <= ST_SUM;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
               ST_SUM: begin
                  if (dx_ff == k_eff - 1'b1) begin
                     dx_ff   <= '0;
                     x_ff    <= x0_ff;
                     dy_ff   <= dy_ff + 1'b1;
                     y_ff    <= y_ff + (ROW_W + 1)'(1);
                     slot_ff <= (slot_ff == SLW'(MAX_KERNEL - 1)) ? '0 : slot_ff + 1'b1;
                     if (dy_ff == k_eff - 1'b1) begin
                        state_ff <= ST_WAIT;
                     end
                  end else begin
                     dx_ff <= dx_ff + 1'b1;
                     x_ff  <= x_ff + XW'(1);
                  end
               end
               ST_WAIT: begin
                  state_ff <= ST_DIVS;
               end
               ST_DIVS: begin
                  state_ff <= ST_DIV;
               end
               ST_DIV: begin
                  if (div_done) begin
                     state_ff <= ST_PUSH;
                  end
               end
               ST_PUSH: begin
                  if (slot_free) begin
                     rsp_data_ff.averaged_pixel  <= div_quo[PIX_W-1:0];
                     rsp_data_ff.last_of_frame   <= is_last;
                     if (is_last) begin
                        in_row_ff   <= '0;
                        in_col_ff   <= '0;
                        in_slot_ff  <= '0;
                        out_row_ff  <= '0;
                        out_col_ff  <= '0;
                        out_slot_ff <= '0;
                     end else if (WW'(out_col_ff) + WW'(1) >= w_eff) begin
                        out_col_ff  <= '0;
                        out_row_ff  <= out_row_ff + 1'b1;
                        out_slot_ff <= (out_slot_ff == SLW'(MAX_KERNEL - 1)) ? '0
                                                                           : out_slot_ff + 1'b1;
                     end else begin
                        out_col_ff <= out_col_ff + 1'b1;
                     end
                     state_ff <= ST_IDLE;
                  end
               end
               default: state_ff <= ST_IDLE;
            endcase
         end

         if (csr_we) begin
            unique case (csr_index)
               CSR_KERNEL_SIZE:  ksize_ff   <= csr_wdata[KSIZE_W-1:0];
               CSR_IMAGE_WIDTH:  iwidth_ff  <= csr_wdata[IWIDTH_W-1:0];
               CSR_IMAGE_HEIGHT: iheight_ff <= csr_wdata[IHEIGHT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   `BFZ_ASSERT_IMP(a_read_from_sum, clock, reset, rd_valid_ff, $past(state_ff == ST_SUM), "memory read outside window pass")
   `BFZ_ASSERT_IMP(a_row_bound, clock, reset, 1'b1, in_row_ff <= h_eff, "input row beyond frame")
   `BFZ_ASSERT_NXT(a_push_result, clock, reset, push_fire, rsp_valid_ff && (state_ff == ST_IDLE), "result not loaded")

endmodule
